### rtl/gbr_pkg.sv
`default_nettype none
package gbr_pkg;

  // window geometry
  localparam int WINDOW_LEN  = 30;
  localparam int SAMPLE_BITS = 16;
  localparam int IDX_W       = $clog2(WINDOW_LEN);

  // field widths
  localparam int DT_W     = 20;
  localparam int THR_W    = 16;
  localparam int GAIN_W   = 32;
  localparam int GHALF_W  = GAIN_W / 2;
  localparam int ANGLE_W  = 32;
  localparam int OFFSET_W = 16;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;

  // datapath widths
  localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW_LEN);
  localparam int MAG_W   = SUM_W;
  localparam int QP_W    = 2 * MAG_W;
  localparam int SPAN_W  = SAMPLE_BITS + 1;
  localparam int CMP_W   = (SPAN_W > THR_W) ? SPAN_W : THR_W;
  localparam int DIFF_W  = SAMPLE_BITS + 1;
  localparam int DMAG_W  = SAMPLE_BITS;
  localparam int PROD_W  = DMAG_W + DT_W;
  localparam int PART_W  = PROD_W + GHALF_W;
  localparam int MUL_A_W = PROD_W;
  localparam int MUL_B_W = (DT_W > GHALF_W) ? DT_W : GHALF_W;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 48;
  localparam int ANGLE_LSB = 16;

  // reciprocal of the window length, floor(2^MAG_W / WINDOW_LEN)
  localparam logic [MAG_W-1:0] RECIP = MAG_W'((64'd1 << MAG_W) / WINDOW_LEN);

  // register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 2'd1;
  localparam logic [THR_W-1:0]     THR_RESET     = 16'd100;
  localparam logic [GAIN_W-1:0]    GAIN_RESET    = 32'd2162235;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] rate_sample;
    logic [DT_W-1:0]               elapsed_us;
  } in_word_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0]  angle_q16;
    logic signed [OFFSET_W-1:0] bias_offset;
    logic                       stationary;
  } out_word_t;

  // window statistics handed from the scan to the integrator
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] hi;
    logic signed [SAMPLE_BITS-1:0] lo;
    logic signed [SUM_W-1:0]       sum;
  } win_stats_t;

endpackage
`default_nettype wire

### rtl/gbr_ram.sv
`default_nettype none
module gbr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 30
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

### rtl/gbr_window.sv
`default_nettype none
module gbr_window (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 wr_en,
  input  wire logic signed [gbr_pkg::SAMPLE_BITS-1:0] wr_sample,
  input  wire logic                                 scan_start,
  output logic                                      scan_done,
  output gbr_pkg::win_stats_t                       stats
);

  logic [gbr_pkg::IDX_W-1:0]       wr_idx_r;
  logic [gbr_pkg::WINDOW_LEN-1:0]  valid_r;
  logic [gbr_pkg::IDX_W-1:0]       rd_idx_r;
  logic                            rd_busy_r;
  logic                            pend_r;
  logic                            pend_ok_r;
  logic                            pend_last_r;
  logic                            first_r;
  logic                            done_r;
  logic [gbr_pkg::SAMPLE_BITS-1:0] rd_data;
  logic signed [gbr_pkg::SAMPLE_BITS-1:0] v;
  logic signed [gbr_pkg::SAMPLE_BITS-1:0] hi_r, lo_r;
  logic signed [gbr_pkg::SUM_W-1:0]       sum_r;
  logic                            rd_last;

  gbr_ram #(
    .WIDTH(gbr_pkg::SAMPLE_BITS),
    .DEPTH(gbr_pkg::WINDOW_LEN)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_idx_r),
    .wr_data(wr_sample),
    .rd_addr(rd_idx_r),
    .rd_data(rd_data)
  );

  // write pointer and per-entry valid bits, never-written entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      valid_r  <= '0;
    end else if (wr_en) begin
      valid_r[wr_idx_r] <= 1'b1;
      wr_idx_r <= (wr_idx_r == gbr_pkg::IDX_W'(gbr_pkg::WINDOW_LEN - 1)) ? '0
                : wr_idx_r + 1'b1;
    end
  end

  assign rd_last = (rd_idx_r == gbr_pkg::IDX_W'(gbr_pkg::WINDOW_LEN - 1));

  // read sweep over all entries; the write lands before the first read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_busy_r   <= 1'b0;
      rd_idx_r    <= '0;
      pend_r      <= 1'b0;
      pend_last_r <= 1'b0;
      done_r      <= 1'b0;
    end else begin
      pend_r      <= rd_busy_r;
      pend_last_r <= rd_busy_r & rd_last;
      done_r      <= pend_r & pend_last_r;
      if (scan_start) begin
        rd_busy_r <= 1'b1;
        rd_idx_r  <= '0;
      end else if (rd_busy_r) begin
        rd_busy_r <= !rd_last;
        rd_idx_r  <= rd_last ? '0 : rd_idx_r + 1'b1;
      end
    end
  end

  // entry valid bit follows its read data
  always_ff @(posedge clk) begin
    pend_ok_r <= valid_r[rd_idx_r];
  end

  assign v = pend_ok_r ? $signed(rd_data) : '0;

  // running max, min and sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b0;
    end else if (scan_start) begin
      first_r <= 1'b1;
    end else if (pend_r) begin
      first_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_r) begin
      if (first_r) begin
        hi_r  <= v;
        lo_r  <= v;
        sum_r <= gbr_pkg::SUM_W'(v);
      end else begin
        if (v > hi_r) begin
          hi_r <= v;
        end
        if (v < lo_r) begin
          lo_r <= v;
        end
        sum_r <= sum_r + gbr_pkg::SUM_W'(v);
      end
    end
  end

  assign scan_done = done_r;
  assign stats.hi  = hi_r;
  assign stats.lo  = lo_r;
  assign stats.sum = sum_r;

endmodule
`default_nettype wire

### rtl/gbr_integrator.sv
`default_nettype none
module gbr_integrator (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   start,
  input  wire gbr_pkg::win_stats_t                    stats,
  input  wire logic signed [gbr_pkg::SAMPLE_BITS-1:0] sample,
  input  wire logic [gbr_pkg::DT_W-1:0]               dt,
  input  wire logic [gbr_pkg::THR_W-1:0]              thr,
  input  wire logic [gbr_pkg::GAIN_W-1:0]             gain,
  input  wire logic                                   out_free,
  output logic                                        res_valid,
  output gbr_pkg::out_word_t                          result
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DIV  = 9'b000000010,
    S_FIX  = 9'b000000100,
    S_DIFF = 9'b000001000,
    S_MDT  = 9'b000010000,
    S_MLO  = 9'b000100000,
    S_MHI  = 9'b001000000,
    S_SUM  = 9'b010000000,
    S_ACC  = 9'b100000000
  } igr_state_t;

  igr_state_t state_r, state_nxt;

  logic [gbr_pkg::SPAN_W-1:0]  span;
  logic                        still_r;
  logic                        neg_r;
  logic [gbr_pkg::MAG_W-1:0]   smag;
  logic [gbr_pkg::MAG_W-1:0]   smag_r;
  logic [gbr_pkg::QP_W-1:0]    qprod_r;
  logic [gbr_pkg::MAG_W-1:0]   q0, rem, q;
  logic [gbr_pkg::SAMPLE_BITS-1:0] qs;
  logic signed [gbr_pkg::SAMPLE_BITS-1:0] mean;
  logic signed [gbr_pkg::SAMPLE_BITS-1:0] offset_r;
  logic signed [gbr_pkg::DIFF_W-1:0] diff;
  logic                        dneg_r;
  logic [gbr_pkg::DMAG_W-1:0]  dmag_r;
  logic [gbr_pkg::MUL_A_W-1:0] mul_a;
  logic [gbr_pkg::MUL_B_W-1:0] mul_b;
  logic [gbr_pkg::MUL_P_W-1:0] mul_p;
  logic [gbr_pkg::PROD_W-1:0]  prod_r;
  logic [gbr_pkg::PROD_W-1:0]  lo_sh_r;
  logic [gbr_pkg::PART_W-1:0]  part_r;
  logic [gbr_pkg::ACC_W-1:0]   inc_r;
  logic [gbr_pkg::ACC_W-1:0]   accum_r, accum_nxt;
  logic                        fire;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = S_DIV;
      S_DIV:   state_nxt = S_FIX;
      S_FIX:   state_nxt = S_DIFF;
      S_DIFF:  state_nxt = S_MDT;
      S_MDT:   state_nxt = S_MLO;
      S_MLO:   state_nxt = S_MHI;
      S_MHI:   state_nxt = S_SUM;
      S_SUM:   state_nxt = S_ACC;
      S_ACC:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // window range test and magnitude of the sum
  assign span = gbr_pkg::SPAN_W'(stats.hi) - gbr_pkg::SPAN_W'(stats.lo);
  assign smag = stats.sum[gbr_pkg::SUM_W-1] ? gbr_pkg::MAG_W'(-stats.sum)
              : gbr_pkg::MAG_W'(stats.sum);

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      still_r <= (gbr_pkg::CMP_W'(span) < gbr_pkg::CMP_W'(thr));
      neg_r   <= stats.sum[gbr_pkg::SUM_W-1];
      smag_r  <= smag;
    end
  end

  // mean by reciprocal multiply, then one correction step
  always_ff @(posedge clk) begin
    if (state_r == S_DIV) begin
      qprod_r <= gbr_pkg::QP_W'(smag_r) * gbr_pkg::QP_W'(gbr_pkg::RECIP);
    end
  end

  assign q0   = qprod_r[gbr_pkg::QP_W-1:gbr_pkg::MAG_W];
  assign rem  = smag_r - gbr_pkg::MAG_W'(q0 * gbr_pkg::WINDOW_LEN);
  assign q    = (rem >= gbr_pkg::MAG_W'(gbr_pkg::WINDOW_LEN)) ? q0 + 1'b1 : q0;
  assign qs   = gbr_pkg::SAMPLE_BITS'(q);
  assign mean = neg_r ? $signed(~qs + 1'b1) : $signed(qs);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
    end else if (state_r == S_FIX && still_r) begin
      offset_r <= mean;
    end
  end

  // corrected rate as sign and magnitude
  assign diff = gbr_pkg::DIFF_W'(sample) - gbr_pkg::DIFF_W'(offset_r);

  always_ff @(posedge clk) begin
    if (state_r == S_DIFF) begin
      dneg_r <= diff[gbr_pkg::DIFF_W-1];
      dmag_r <= diff[gbr_pkg::DIFF_W-1] ? gbr_pkg::DMAG_W'(-diff)
              : gbr_pkg::DMAG_W'(diff);
    end
  end

  // one shared multiplier: |diff| * dt, then the two gain halves
  always_comb begin
    mul_a = gbr_pkg::MUL_A_W'(dmag_r);
    mul_b = gbr_pkg::MUL_B_W'(dt);
    case (state_r)
      S_MLO: begin
        mul_a = prod_r;
        mul_b = gbr_pkg::MUL_B_W'(gain[gbr_pkg::GHALF_W-1:0]);
      end
      S_MHI: begin
        mul_a = prod_r;
        mul_b = gbr_pkg::MUL_B_W'(gain[gbr_pkg::GAIN_W-1:gbr_pkg::GHALF_W]);
      end
      default: begin
        mul_a = gbr_pkg::MUL_A_W'(dmag_r);
        mul_b = gbr_pkg::MUL_B_W'(dt);
      end
    endcase
  end

  assign mul_p = gbr_pkg::MUL_P_W'(mul_a) * gbr_pkg::MUL_P_W'(mul_b);

  always_ff @(posedge clk) begin
    case (state_r)
      S_MDT: prod_r  <= gbr_pkg::PROD_W'(mul_p);
      S_MLO: lo_sh_r <= mul_p[gbr_pkg::PART_W-1:gbr_pkg::GHALF_W];
      S_MHI: part_r  <= mul_p[gbr_pkg::PART_W-1:0];
      S_SUM: inc_r   <= part_r[gbr_pkg::ACC_W-1:0] + gbr_pkg::ACC_W'(lo_sh_r);
      default: begin
      end
    endcase
  end

  // wrapping angle accumulator
  assign fire      = (state_r == S_ACC) && out_free;
  assign accum_nxt = dneg_r ? accum_r - inc_r : accum_r + inc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= '0;
    end else if (fire) begin
      accum_r <= accum_nxt;
    end
  end

  assign res_valid          = fire;
  assign result.angle_q16   =
    $signed(accum_nxt[gbr_pkg::ANGLE_LSB+gbr_pkg::ANGLE_W-1:gbr_pkg::ANGLE_LSB]);
  assign result.bias_offset = gbr_pkg::OFFSET_W'(offset_r);
  assign result.stationary  = still_r;

endmodule
`default_nettype wire

### rtl/gyro_bias_rezero_integrator.sv
`default_nettype none
// channel | direction | handshake             | payload
// in_     | input     | in_valid / in_ready   | in_word_t: rate_sample, elapsed_us
// out_    | output    | out_valid / out_ready | out_word_t: angle_q16, bias_offset, stationary
// cfg_    | input     | cfg_wr_en             | cfg_index, cfg_data
//
// one word at a time: the window memory is swept one entry a cycle through its single
// read port, then the mean, rate product and accumulate run as a short sequence around
// one shared multiplier.
// synchronous active-low reset clears window valid bits, offset, angle; reloads config.
// the next word is taken as soon as the result sits in the output register; a stalled
// output holds only the accumulate step.
module gyro_bias_rezero_integrator (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire gbr_pkg::in_word_t                in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output gbr_pkg::out_word_t                    out_data,
  input  wire logic                             cfg_wr_en,
  input  wire logic [gbr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [gbr_pkg::CFG_W-1:0]        cfg_data
);

  logic                          busy_r;
  logic                          in_fire;
  gbr_pkg::in_word_t             word_r;
  logic [gbr_pkg::THR_W-1:0]     thr_r, thr_nxt;
  logic [gbr_pkg::GAIN_W-1:0]    gain_r, gain_nxt;
  logic                          scan_done;
  gbr_pkg::win_stats_t           stats;
  logic                          out_free;
  logic                          res_valid;
  gbr_pkg::out_word_t            result;
  logic                          out_valid_r;
  gbr_pkg::out_word_t            out_word_r;

  // config registers
  always_comb begin
    thr_nxt  = thr_r;
    gain_nxt = gain_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        gbr_pkg::REG_THRESHOLD: thr_nxt  = cfg_data[gbr_pkg::THR_W-1:0];
        gbr_pkg::REG_GAIN:      gain_nxt = cfg_data[gbr_pkg::GAIN_W-1:0];
        default:                thr_nxt  = thr_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= gbr_pkg::THR_RESET;
      gain_r <= gbr_pkg::GAIN_RESET;
    end else begin
      thr_r  <= thr_nxt;
      gain_r <= gain_nxt;
    end
  end

  // one word in flight
  assign in_ready = !busy_r;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_fire) begin
      busy_r <= 1'b1;
    end else if (res_valid) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      word_r <= in_data;
    end
  end

  gbr_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (in_fire),
    .wr_sample (in_data.rate_sample),
    .scan_start(in_fire),
    .scan_done (scan_done),
    .stats     (stats)
  );

  gbr_integrator u_integrator (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (scan_done),
    .stats    (stats),
    .sample   (word_r.rate_sample),
    .dt       (word_r.elapsed_us),
    .thr      (thr_r),
    .gain     (gain_r),
    .out_free (out_free),
    .res_valid(res_valid),
    .result   (result)
  );

  // output register
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_word_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  // a result only comes out of a word in flight
  a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> busy_r)
    else $error("result produced with no word in flight");

  // the window scan only finishes for a word in flight
  a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
    scan_done |-> busy_r && !in_ready)
    else $error("window scan finished while idle");

  // an accepted word never yields a result or a finished scan in the very next cycle
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !res_valid && !scan_done)
    else $error("result too soon after accept");

  // a produced result lands in the output register
  a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> out_valid && !busy_r)
    else $error("result not registered");

endmodule
`default_nettype wire
